@@ src/pfes_pkg.sv @@
// ----------------------------------------------------------------------------
// pfes_pkg
// Shared types and constants for the function extent scanner: PowerPC opcode
// fields, end causes and the structures passed between the scanner modules.
// ----------------------------------------------------------------------------
package pfes_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 16;

	localparam logic [WORD_W-1:0] CODE_BLR  = 32'h4E80_0020;
	localparam logic [WORD_W-1:0] CODE_BCTR = 32'h4E80_0420;

	localparam logic [5:0] OP_BC = 6'd16;
	localparam logic [5:0] OP_B  = 6'd18;
	localparam logic [5:0] OP_XL = 6'd19;
	localparam logic [5:0] OP_X  = 6'd31;

	localparam logic [9:0] XO_BCLR  = 10'd16;
	localparam logic [9:0] XO_BCCTR = 10'd528;
	localparam logic [9:0] XO_MFSPR = 10'd339;

	// The SPR field is stored with its two halves swapped; LR is SPR 8.
	localparam logic [4:0] SPR_LR_LO = 5'd8;
	localparam logic [4:0] SPR_LR_HI = 5'd0;

	localparam logic [COUNT_W-1:0] BLOCK_MAX = '1;

	localparam logic [WORD_W-1:0] WORD_STEP = 32'd4;

	typedef enum logic [0:0] {
		CFG_START_ADDRESS = 1'b0,
		CFG_END_BOUND     = 1'b1
	} pfes_cfg_idx_t;

	typedef enum logic [2:0] {
		CAUSE_NONE   = 3'd0,
		CAUSE_ZERO   = 3'd1,
		CAUSE_BLR    = 3'd2,
		CAUSE_BCTR   = 3'd3,
		CAUSE_BACK   = 3'd4,
		CAUSE_BEFORE = 3'd5,
		CAUSE_THUNK  = 3'd6,
		CAUSE_BOUND  = 3'd7
	} pfes_cause_t;

	typedef struct packed {
		logic              is_zero;
		logic              is_blr;
		logic              is_bctr;
		logic              is_b;
		logic              is_bc;
		logic              is_bxr;
		logic              is_mflr;
		logic              aa;
		logic              lk;
		logic [WORD_W-1:0] disp;
	} pfes_dec_t;

	typedef struct packed {
		logic [WORD_W-1:0]  cur_address;
		logic [WORD_W-1:0]  far_target;
		logic [COUNT_W-1:0] block_count;
		logic               inside_block;
		logic               has_prolog;
		logic               finished;
	} pfes_state_t;

	typedef struct packed {
		logic [WORD_W-1:0]  word_address;
		logic               done_res;
		logic [WORD_W-1:0]  end_addr;
		pfes_cause_t        cause;
		logic [COUNT_W-1:0] block_total;
		logic               prolog_seen;
	} pfes_result_t;

endpackage

@@ src/pfes_decode.sv @@
// ----------------------------------------------------------------------------
// pfes_decode
// Classifies one big-endian PowerPC instruction word by its primary and
// extended opcode fields and extracts the branch displacement.
// ----------------------------------------------------------------------------
module pfes_decode (
	input  logic [31:0]         instr_word,
	output pfes_pkg::pfes_dec_t dec
);
	import pfes_pkg::*;

	logic [5:0]        prim;
	logic [9:0]        xo;
	logic [WORD_W-1:0] li;
	logic [WORD_W-1:0] bd;

	assign prim = instr_word[31:26];
	assign xo   = instr_word[10:1];
	assign li   = {{6{instr_word[25]}}, instr_word[25:2], 2'b00};
	assign bd   = {{16{instr_word[15]}}, instr_word[15:2], 2'b00};

	always_comb begin
		dec.is_zero = (instr_word == '0);
		dec.is_blr  = (instr_word == CODE_BLR);
		dec.is_bctr = (instr_word == CODE_BCTR);
		dec.is_b    = (prim == OP_B);
		dec.is_bc   = (prim == OP_BC);
		dec.is_bxr  = (prim == OP_XL) && ((xo == XO_BCLR) || (xo == XO_BCCTR));
		dec.is_mflr = (prim == OP_X) && (xo == XO_MFSPR) &&
			(instr_word[20:16] == SPR_LR_LO) && (instr_word[15:11] == SPR_LR_HI);
		dec.aa      = instr_word[1];
		dec.lk      = instr_word[0];
		dec.disp    = (prim == OP_B) ? li : bd;
	end

endmodule

@@ src/pfes_core.sv @@
// ----------------------------------------------------------------------------
// pfes_core
// Scan state and the single-pass update for one instruction word: branch
// target tracking, block counting, prolog detection and end detection.
// ----------------------------------------------------------------------------
module pfes_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step_en,
	input  logic                   first,
	input  logic [31:0]            instr_word,
	input  logic [31:0]            scan_base,
	input  logic [31:0]            end_bound,
	output pfes_pkg::pfes_result_t res
);
	import pfes_pkg::*;

	pfes_dec_t   dec;
	pfes_state_t st_q;
	pfes_state_t eff;
	pfes_state_t nxt;

	pfes_decode u_decode (
		.instr_word (instr_word),
		.dec        (dec)
	);

	always_comb begin
		logic [WORD_W-1:0] addr;
		logic [WORD_W-1:0] tgt;
		logic [WORD_W:0]   sum;
		logic              clear;
		logic              ends_fn;
		logic              blk_end;
		logic              done;
		logic [WORD_W-1:0] endv;
		pfes_cause_t       cause;

		eff = st_q;
		if (first) begin
			eff.cur_address  = scan_base;
			eff.far_target   = scan_base;
			eff.block_count  = '0;
			eff.inside_block = 1'b0;
			eff.has_prolog   = 1'b0;
			eff.finished     = 1'b0;
		end

		nxt        = eff;
		addr       = eff.cur_address;
		tgt        = dec.disp + (dec.aa ? '0 : addr);
		sum        = {1'b0, addr} + {1'b0, WORD_STEP};
		clear      = (eff.far_target <= addr);
		ends_fn    = 1'b0;
		blk_end    = 1'b0;
		done       = 1'b0;
		endv       = '0;
		cause      = CAUSE_NONE;

		if (!eff.finished) begin
			if (dec.is_zero) begin
				done  = 1'b1;
				endv  = addr - WORD_STEP;
				cause = CAUSE_ZERO;
			end else begin
				if ((addr == scan_base) && dec.is_mflr) begin
					nxt.has_prolog = 1'b1;
				end
				if (!eff.inside_block && (eff.block_count != BLOCK_MAX)) begin
					nxt.block_count = eff.block_count + COUNT_W'(1);
				end

				if (dec.is_blr || dec.is_bctr) begin
					if (!(eff.far_target > addr)) begin
						ends_fn = 1'b1;
						cause   = dec.is_blr ? CAUSE_BLR : CAUSE_BCTR;
					end
					blk_end = 1'b1;
				end else if (dec.is_b) begin
					if (!dec.lk) begin
						if ((tgt >= scan_base) && (tgt < addr) && clear) begin
							ends_fn = 1'b1;
							cause   = CAUSE_BACK;
						end else if ((tgt < scan_base) && clear) begin
							ends_fn = 1'b1;
							cause   = CAUSE_BEFORE;
						end else if (!nxt.has_prolog && (nxt.block_count == COUNT_W'(1))) begin
							ends_fn = 1'b1;
							cause   = CAUSE_THUNK;
						end else if (tgt > eff.far_target) begin
							nxt.far_target = tgt;
						end
					end
					blk_end = 1'b1;
				end else if (dec.is_bc) begin
					if (!dec.lk && (tgt > eff.far_target)) begin
						nxt.far_target = tgt;
					end
					blk_end = 1'b1;
				end else if (dec.is_bxr) begin
					blk_end = 1'b1;
				end

				nxt.inside_block = !blk_end;

				if (ends_fn) begin
					done = 1'b1;
					endv = addr;
				end else begin
					nxt.cur_address = sum[WORD_W-1:0];
					if ((end_bound != '0) && (sum[WORD_W] || (sum[WORD_W-1:0] > end_bound))) begin
						done  = 1'b1;
						endv  = sum[WORD_W-1:0];
						cause = CAUSE_BOUND;
					end
				end
			end
			if (done) begin
				nxt.finished = 1'b1;
			end
		end

		res.word_address = addr;
		res.done_res     = done;
		res.end_addr     = endv;
		res.cause        = cause;
		res.block_total  = nxt.block_count;
		res.prolog_seen  = nxt.has_prolog;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.cur_address  <= '0;
			st_q.far_target   <= '0;
			st_q.block_count  <= '0;
			st_q.inside_block <= 1'b0;
			st_q.has_prolog   <= 1'b0;
			st_q.finished     <= 1'b1;
		end else if (step_en) begin
			st_q <= nxt;
		end
	end

	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |-> (res.done_res == (res.cause != CAUSE_NONE)))
		else $error("End flag and end cause disagree.");

	a_done_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && res.done_res) |=> st_q.finished)
		else $error("Scan did not finish after reporting an end.");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(st_q))
		else $error("Scan state changed without a word.");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && !first) |=> (st_q.block_count >= $past(st_q.block_count)))
		else $error("Block count fell within a scan.");

endmodule

@@ src/ppc_function_extent_scanner.sv @@
// ----------------------------------------------------------------------------
// ppc_function_extent_scanner
// Scans a stream of PowerPC instruction words and reports where the function
// that starts at the configured address ends.
// ----------------------------------------------------------------------------
// Instruction words arrive on the input channel (in_valid, in_stall) in
// address order; a word with first set restarts the scan at the configured
// start address.
// Every accepted word yields exactly one result word on the output channel
// (out_valid, out_stall) carrying its address, the end flag and cause, the
// end address, the block count and the prolog flag.
// Configuration is written through cfg_valid/cfg_ready, index 0 being the
// start address and index 1 the end bound; cfg_ready is always high, and
// writes are expected only while no word is in flight.
// A word is registered on entry, processed combinationally against the scan
// state and registered as a result, so it passes through the input register
// and then the result register; one word per cycle is sustained while
// out_stall stays low.
// A stalled result holds; the input register stalls only when it is full and
// the result register cannot move. Reset clears both and leaves the scanner
// idle, ignoring words until one arrives with first set.
// ----------------------------------------------------------------------------
module ppc_function_extent_scanner (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        first,
	input  logic [31:0] instr_word,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] word_address,
	output logic        done_res,
	output logic [31:0] end_addr,
	output logic [2:0]  cause,
	output logic [15:0] block_total,
	output logic        prolog_seen,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import pfes_pkg::*;

	logic [WORD_W-1:0] scan_base_q;
	logic [WORD_W-1:0] end_bound_q;

	logic              valid_s1;
	logic              first_s1;
	logic [WORD_W-1:0] word_s1;

	logic              valid_s2;
	pfes_result_t      res_s2;
	pfes_result_t      res;

	logic              advance;
	logic              step_en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_base_q <= '0;
			end_bound_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (pfes_cfg_idx_t'(cfg_index))
				CFG_START_ADDRESS: scan_base_q <= cfg_data;
				CFG_END_BOUND:     end_bound_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	assign advance  = !valid_s2 || !out_stall;
	assign step_en  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			first_s1 <= first;
			word_s1  <= instr_word;
		end
	end

	pfes_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (step_en),
		.first      (first_s1),
		.instr_word (word_s1),
		.scan_base  (scan_base_q),
		.end_bound  (end_bound_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign word_address = res_s2.word_address;
	assign done_res     = res_s2.done_res;
	assign end_addr     = res_s2.end_addr;
	assign cause        = res_s2.cause;
	assign block_total  = res_s2.block_total;
	assign prolog_seen  = res_s2.prolog_seen;

endmodule

@@ tb/sv/ppc_function_extent_scanner_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppc_function_extent_scanner_test
// Self-checking testbench for the function extent scanner.
// A short table of hand-written scans covers every end cause, restarts, idle
// words, the bound and the wrap at the top of the address space; random
// scans of plausible code with some noise follow. Each result word is
// checked field by field against the table's expected values or a scan
// predictor kept inside the testbench, under random gaps and stalls.
// ----------------------------------------------------------------------------
module ppc_function_extent_scanner_test;
	import pfes_pkg::*;

	localparam int RANDOM_WORDS = 1600;

	typedef struct {
		bit            is_cfg;
		pfes_cfg_idx_t idx;
		logic          fw;
		logic [31:0]   val;
		bit            typed;
		pfes_result_t  res;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        first;
	logic [31:0] instr_word;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] word_address;
	logic        done_res;
	logic [31:0] end_addr;
	logic [2:0]  cause;
	logic [15:0] block_total;
	logic        prolog_seen;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_data;

	// Scanner state as predicted.
	logic [31:0] sc_start;
	logic [31:0] sc_bound;
	logic [31:0] sc_cur;
	logic [31:0] sc_far;
	logic [15:0] sc_blocks;
	logic        sc_inblock;
	logic        sc_prolog;
	logic        sc_finished;

	pfes_result_t pending_scan_results[$];
	plan_row_t    plan[$];
	int           mismatches;
	int           words_sent;
	bit           steady;

	ppc_function_extent_scanner dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.first        (first),
		.instr_word   (instr_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.word_address (word_address),
		.done_res     (done_res),
		.end_addr     (end_addr),
		.cause        (cause),
		.block_total  (block_total),
		.prolog_seen  (prolog_seen),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic pfes_result_t scan_word(input logic fw, input logic [31:0] w);
		pfes_result_t r;
		logic [31:0]  here;
		logic [31:0]  tgt;
		logic [31:0]  nxt;
		logic [31:0]  endv;
		logic [5:0]   prim;
		logic [9:0]   xo;
		logic [9:0]   spr;
		logic         ends_fn;
		logic         ends_blk;
		logic         done;
		logic         carry;
		logic         clear;
		pfes_cause_t  why;
		ends_fn  = 1'b0;
		ends_blk = 1'b0;
		done     = 1'b0;
		endv     = '0;
		why      = CAUSE_NONE;
		if (fw) begin
			sc_cur      = sc_start;
			sc_far      = sc_start;
			sc_blocks   = '0;
			sc_inblock  = 1'b0;
			sc_prolog   = 1'b0;
			sc_finished = 1'b0;
		end
		here = sc_cur;
		if (!sc_finished) begin
			prim = w[31:26];
			xo   = w[10:1];
			spr  = w[20:11];
			if (w == '0) begin
				done = 1'b1;
				endv = here - WORD_STEP;
				why  = CAUSE_ZERO;
			end else begin
				if (here == sc_start && prim == OP_X && xo == XO_MFSPR &&
						spr[9:5] == SPR_LR_LO && spr[4:0] == SPR_LR_HI)
					sc_prolog = 1'b1;
				if (!sc_inblock) begin
					sc_inblock = 1'b1;
					if (sc_blocks != BLOCK_MAX)
						sc_blocks++;
				end
				if (w == CODE_BLR || w == CODE_BCTR) begin
					if (!(sc_far > here)) begin
						ends_fn = 1'b1;
						why = (w == CODE_BLR) ? CAUSE_BLR : CAUSE_BCTR;
					end
					ends_blk = 1'b1;
				end else if (prim == OP_B) begin
					tgt = {{6{w[25]}}, w[25:2], 2'b00} + (w[1] ? 32'd0 : here);
					if (!w[0]) begin
						clear = (sc_far <= here);
						if (tgt >= sc_start && tgt < here && clear) begin
							ends_fn = 1'b1;
							why = CAUSE_BACK;
						end else if (tgt < sc_start && clear) begin
							ends_fn = 1'b1;
							why = CAUSE_BEFORE;
						end else if (!sc_prolog && sc_blocks == 16'd1) begin
							ends_fn = 1'b1;
							why = CAUSE_THUNK;
						end else if (tgt > sc_far) begin
							sc_far = tgt;
						end
					end
					ends_blk = 1'b1;
				end else if (prim == OP_BC) begin
					tgt = {{16{w[15]}}, w[15:2], 2'b00} + (w[1] ? 32'd0 : here);
					if (!w[0] && tgt > sc_far)
						sc_far = tgt;
					ends_blk = 1'b1;
				end else if (prim == OP_XL && (xo == XO_BCLR || xo == XO_BCCTR)) begin
					ends_blk = 1'b1;
				end
				if (ends_blk)
					sc_inblock = 1'b0;
				if (ends_fn) begin
					done = 1'b1;
					endv = here;
				end else begin
					{carry, nxt} = {1'b0, here} + {1'b0, WORD_STEP};
					sc_cur = nxt;
					if (sc_bound != '0 && (carry || nxt > sc_bound)) begin
						done = 1'b1;
						endv = nxt;
						why  = CAUSE_BOUND;
					end
				end
			end
			if (done)
				sc_finished = 1'b1;
		end
		r.word_address = here;
		r.done_res     = done;
		r.end_addr     = done ? endv : 32'd0;
		r.cause        = why;
		r.block_total  = sc_blocks;
		r.prolog_seen  = sc_prolog;
		return r;
	endfunction

	function automatic logic [31:0] mflr_word(input logic [4:0] rd);
		return {OP_X, rd, SPR_LR_LO, SPR_LR_HI, XO_MFSPR, 1'b0};
	endfunction

	function automatic logic [31:0] body_word();
		logic [31:0] w;
		logic [31:0] tgt;
		logic [4:0]  bo;
		logic [4:0]  bi;
		int          d;
		do
			w = $urandom;
		while (w[31:26] == OP_B || w[31:26] == OP_BC || w[31:26] == OP_XL || w == '0);
		d   = (int'($urandom_range(0, 40)) - 20) * 4;
		tgt = sc_start + d;
		bo  = 5'($urandom);
		bi  = 5'($urandom);
		case ($urandom_range(0, 19))
			8: w = CODE_BLR;
			9: w = CODE_BCTR;
			10, 11: w = {OP_B, d[25:2], 1'b0, 1'($urandom_range(0, 3) == 0)};
			12, 13: w = {OP_BC, bo, bi, d[15:2], 1'b0, 1'($urandom_range(0, 3) == 0)};
			14: w = {OP_XL, bo, bi, 5'd0, ($urandom_range(0, 1) ? XO_BCLR : XO_BCCTR),
				1'($urandom_range(0, 1))};
			15: w = {OP_B, tgt[25:2], 1'b1, 1'($urandom_range(0, 3) == 0)};
			16: w = {OP_BC, bo, bi, tgt[15:2], 1'b1, 1'b0};
			17: if ($urandom_range(0, 3) == 0) w = '0;
			18: w = $urandom;
			19: w = mflr_word(5'($urandom));
			default: ;
		endcase
		return w;
	endfunction

	function automatic logic [31:0] opening_word();
		case ($urandom_range(0, 7))
			0, 1, 2: return mflr_word(5'($urandom));
			3: return {OP_X, 5'($urandom), 5'd9, 5'd0, XO_MFSPR, 1'b0};
			4: return mflr_word(5'($urandom)) | 32'd1;
			default: return body_word();
		endcase
	endfunction

	function automatic void plan_cfg(input pfes_cfg_idx_t idx, input logic [31:0] val);
		plan_row_t row;
		row.is_cfg = 1'b1;
		row.idx    = idx;
		row.fw     = 1'b0;
		row.val    = val;
		row.typed  = 1'b0;
		row.res    = '0;
		plan.push_back(row);
	endfunction

	function automatic void plan_word(input logic fw, input logic [31:0] w);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.idx    = CFG_START_ADDRESS;
		row.fw     = fw;
		row.val    = w;
		row.typed  = 1'b0;
		row.res    = '0;
		plan.push_back(row);
	endfunction

	function automatic void plan_known(input logic fw, input logic [31:0] w,
			input logic [31:0] a, input logic d, input logic [31:0] e,
			input pfes_cause_t c, input logic [15:0] b, input logic p);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.idx    = CFG_START_ADDRESS;
		row.fw     = fw;
		row.val    = w;
		row.typed  = 1'b1;
		row.res    = '{word_address: a, done_res: d, end_addr: e, cause: c,
			block_total: b, prolog_seen: p};
		plan.push_back(row);
	endfunction

	task automatic send_word(input logic fw, input logic [31:0] w, input bit typed,
			input pfes_result_t given);
		int           gap;
		pfes_result_t r;
		gap = steady ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid   = 1'b1;
		first      = fw;
		instr_word = w;
		do
			@(posedge clk);
		while (in_stall);
		r = scan_word(fw, w);
		pending_scan_results.push_back(typed ? given : r);
	endtask

	task automatic write_reg(input pfes_cfg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_scan_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == CFG_START_ADDRESS)
			sc_start = val;
		else
			sc_bound = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
	endtask

	always @(posedge clk) begin
		pfes_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_scan_results.size() == 0) begin
				flag_mismatch("unexpected result word", '0, word_address);
			end else begin
				want = pending_scan_results.pop_front();
				if (want.word_address !== word_address)
					flag_mismatch("word_address", want.word_address, word_address);
				if (want.done_res !== done_res)
					flag_mismatch("done_res", 32'(want.done_res), 32'(done_res));
				if (want.end_addr !== end_addr)
					flag_mismatch("end_addr", want.end_addr, end_addr);
				if (want.cause !== cause)
					flag_mismatch("cause", 32'(want.cause), 32'(cause));
				if (want.block_total !== block_total)
					flag_mismatch("block_total", 32'(want.block_total), 32'(block_total));
				if (want.prolog_seen !== prolog_seen)
					flag_mismatch("prolog_seen", 32'(want.prolog_seen), 32'(prolog_seen));
			end
		end
	end

	initial begin : result_sink
		int hold;
		out_stall = 1'b0;
		forever begin
			hold = steady ? 0 : $urandom_range(0, 5);
			repeat (hold) begin
				@(negedge clk);
				out_stall = 1'b1;
			end
			@(negedge clk);
			out_stall = 1'b0;
			do
				@(posedge clk);
			while (!(arst_n && out_valid));
		end
	end

	initial begin
		#(64'd10_000_000);
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		int          len;
		int          k;
		logic        fw;
		logic [31:0] w;
		logic [31:0] base;
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		first       = 1'b0;
		instr_word  = '0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_START_ADDRESS;
		cfg_data    = '0;
		sc_start    = '0;
		sc_bound    = '0;
		sc_cur      = '0;
		sc_far      = '0;
		sc_blocks   = '0;
		sc_inblock  = 1'b0;
		sc_prolog   = 1'b0;
		sc_finished = 1'b1;
		mismatches  = 0;
		words_sent  = 0;
		steady      = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		plan_known(1'b0, 32'h1234_5678, 32'h0, 1'b0, 32'h0, CAUSE_NONE, 16'd0, 1'b0);
		plan_cfg(CFG_START_ADDRESS, 32'h0000_1000);
		plan_cfg(CFG_END_BOUND, 32'h0);
		plan_known(1'b1, mflr_word(5'd0), 32'h1000, 1'b0, 32'h0, CAUSE_NONE, 16'd1, 1'b1);
		plan_word(1'b0, 32'h3860_0000);
		plan_known(1'b0, CODE_BLR, 32'h1008, 1'b1, 32'h1008, CAUSE_BLR, 16'd1, 1'b1);
		plan_known(1'b0, 32'h0, 32'h1008, 1'b0, 32'h0, CAUSE_NONE, 16'd1, 1'b1);
		plan_known(1'b1, 32'h0, 32'h1000, 1'b1, 32'h0FFC, CAUSE_ZERO, 16'd0, 1'b0);
		plan_known(1'b1, 32'h4800_0010, 32'h1000, 1'b1, 32'h1000, CAUSE_THUNK, 16'd1, 1'b0);
		plan_word(1'b1, mflr_word(5'd0));
		plan_word(1'b0, 32'h6000_0000);
		plan_known(1'b0, 32'h4BFF_FFFC, 32'h1008, 1'b1, 32'h1008, CAUSE_BACK, 16'd1, 1'b1);
		plan_word(1'b1, mflr_word(5'd0));
		plan_known(1'b0, 32'h4BFF_FFF8, 32'h1004, 1'b1, 32'h1004, CAUSE_BEFORE, 16'd1, 1'b1);
		plan_word(1'b1, mflr_word(5'd3));
		plan_word(1'b0, 32'h4182_0010);
		plan_word(1'b0, CODE_BCTR);
		plan_word(1'b0, 32'h4D82_0020);
		plan_word(1'b0, 32'h4800_0101);
		plan_word(1'b0, 32'h4D82_0420);
		plan_word(1'b0, 32'h4800_1002);
		plan_word(1'b1, mflr_word(5'd31));
		plan_known(1'b0, CODE_BCTR, 32'h1004, 1'b1, 32'h1004, CAUSE_BCTR, 16'd1, 1'b1);
		plan_word(1'b1, mflr_word(5'd0));
		plan_word(1'b0, 32'h6000_0000);
		plan_known(1'b1, CODE_BLR, 32'h1000, 1'b1, 32'h1000, CAUSE_BLR, 16'd1, 1'b0);
		plan_cfg(CFG_END_BOUND, 32'h0000_1008);
		plan_word(1'b1, mflr_word(5'd0));
		plan_word(1'b0, 32'h6000_0000);
		plan_known(1'b0, 32'h6000_0000, 32'h1008, 1'b1, 32'h100C, CAUSE_BOUND, 16'd1, 1'b1);
		plan_cfg(CFG_START_ADDRESS, 32'hFFFF_FFFC);
		plan_cfg(CFG_END_BOUND, 32'hFFFF_FFFF);
		plan_known(1'b1, 32'h6000_0000, 32'hFFFF_FFFC, 1'b1, 32'h0, CAUSE_BOUND, 16'd1, 1'b0);
		plan_cfg(CFG_END_BOUND, 32'h0);
		plan_word(1'b1, 32'h6000_0000);
		plan_known(1'b0, 32'h0, 32'h0, 1'b1, 32'hFFFF_FFFC, CAUSE_ZERO, 16'd1, 1'b0);
		plan_cfg(CFG_START_ADDRESS, 32'h0);
		plan_word(1'b1, 32'hFFFF_FFFF);
		plan_word(1'b0, 32'h4080_FFF0);
		plan_word(1'b0, CODE_BLR);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].idx, plan[i].val);
			else
				send_word(plan[i].fw, plan[i].val, plan[i].typed, plan[i].res);
		end

		while (words_sent < RANDOM_WORDS) begin
			steady = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 5))
					0: base = '0;
					1: base = 32'hFFFF_FFFC - $urandom_range(0, 16) * 4;
					default: base = $urandom & 32'hFFFF_FFFC;
				endcase
				write_reg(CFG_START_ADDRESS, base);
				case ($urandom_range(0, 5))
					3: write_reg(CFG_END_BOUND, base + $urandom_range(0, 160));
					4: write_reg(CFG_END_BOUND, 32'hFFFF_FFFF);
					5: write_reg(CFG_END_BOUND, $urandom);
					default: write_reg(CFG_END_BOUND, 32'h0);
				endcase
			end
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(1, 8);
				for (k = 0; k < len; k++) begin
					fw = 1'($urandom_range(0, 1));
					w  = $urandom;
					words_sent++;
					send_word(fw, w, 1'b0, '0);
				end
			end else begin
				len = $urandom_range(1, 40);
				send_word(1'b1, opening_word(), 1'b0, '0);
				words_sent++;
				for (k = 1; k < len && !sc_finished; k++) begin
					send_word(1'b0, body_word(), 1'b0, '0);
					words_sent++;
				end
				if (sc_finished)
					repeat ($urandom_range(0, 2)) begin
						send_word(1'b0, $urandom, 1'b0, '0);
						words_sent++;
					end
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_scan_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
